// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top level RTL of the command risk pattern matcher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is active.
`define CRPM_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// Same check with a caller supplied message.
`define CRPM_ASSERT_MSG(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

`endif

// ===== rtl/core/crpm_pkg.sv =====
// Types, substring table and rule codes of the command risk pattern matcher.
`default_nettype none
package crpm_pkg;

	typedef logic [7:0] char_t;

	localparam int PAT_COUNT = 23;
	localparam int PAT_MAX   = 12;
	localparam int RULE_COUNT = 9;

	typedef logic [8*PAT_MAX-1:0] pat_text_t;
	typedef logic [3:0]           pat_len_t;
	typedef logic [PAT_COUNT-1:0] hits_t;
	typedef logic [RULE_COUNT-1:0] rules_t;
	typedef logic [2:0]           count_t;
	typedef logic [1:0]           risk_t;

	// Text is right aligned: the final character sits in bits [7:0].
	localparam pat_text_t PAT_TEXT [PAT_COUNT] = '{
		"sudo ", "rm -rf", "rm -fr", "curl ", "wget ", "|", " sh", " bash", " zsh",
		"chmod -r", "chown -r", " ~/.ssh", "$home/.ssh", "/.ssh/", " ~/.aws",
		"$home/.aws", "/.aws/", "ssh ", "scp ", "rsync ", "npm install",
		"pip install", "brew install"
	};
	localparam pat_len_t PAT_LEN [PAT_COUNT] = '{
		4'd5, 4'd6, 4'd6, 4'd5, 4'd5, 4'd1, 4'd3, 4'd5, 4'd4,
		4'd8, 4'd8, 4'd7, 4'd10, 4'd6, 4'd7,
		4'd10, 4'd6, 4'd4, 4'd4, 4'd6, 4'd11,
		4'd11, 4'd12
	};

	localparam int P_SUDO     = 0;
	localparam int P_RMRF     = 1;
	localparam int P_RMFR     = 2;
	localparam int P_CURL     = 3;
	localparam int P_WGET     = 4;
	localparam int P_PIPE     = 5;
	localparam int P_SH       = 6;
	localparam int P_BASH     = 7;
	localparam int P_ZSH      = 8;
	localparam int P_CHMOD    = 9;
	localparam int P_CHOWN    = 10;
	localparam int P_TSSH     = 11;
	localparam int P_HSSH     = 12;
	localparam int P_DSSH     = 13;
	localparam int P_TAWS     = 14;
	localparam int P_HAWS     = 15;
	localparam int P_DAWS     = 16;
	localparam int P_SSH      = 17;
	localparam int P_SCP      = 18;
	localparam int P_RSYNC    = 19;
	localparam int P_NPM      = 20;
	localparam int P_PIP      = 21;
	localparam int P_BREW     = 22;

	localparam logic [31:0] SUDO_WORD = "sudo";
	localparam count_t SUDO_PRIOR = 3'd3;
	localparam count_t COUNT_SAT  = 3'd5;

	localparam int R_SUDO     = 0;
	localparam int R_RMRF     = 1;
	localparam int R_CURLPIPE = 2;
	localparam int R_WGETPIPE = 3;
	localparam int R_CHMOD    = 4;
	localparam int R_SSH      = 5;
	localparam int R_AWS      = 6;
	localparam int R_REMOTE   = 7;
	localparam int R_INSTALL  = 8;

	localparam risk_t RISK_LOW    = 2'd0;
	localparam risk_t RISK_MEDIUM = 2'd1;
	localparam risk_t RISK_HIGH   = 2'd2;

	typedef struct packed {
		logic shift;
		logic clear;
	} win_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/crpm_cell.sv =====
// One byte cell of the history chain; takes its neighbor's byte on each shift, clear has priority.
`default_nettype none
module crpm_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire crpm_pkg::win_ctl_t ctl,
	input  wire crpm_pkg::char_t   d,
	output crpm_pkg::char_t        q
);

	crpm_pkg::char_t byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (ctl.clear) begin
			byte_q <= '0;
		end else if (ctl.shift) begin
			byte_q <= d;
		end
	end

	assign q = byte_q;

endmodule
`default_nettype wire

// ===== rtl/core/crpm_match.sv =====
// Parallel suffix compare of the current byte and the history chain.
`default_nettype none
module crpm_match #(
	parameter int WINDOW_DEPTH = 11
) (
	input  wire crpm_pkg::char_t cur,
	input  wire crpm_pkg::char_t win [WINDOW_DEPTH],
	output crpm_pkg::hits_t      hits,
	output logic                 sudo_word
);

	crpm_pkg::char_t tail [crpm_pkg::PAT_MAX];

	always_comb begin
		tail[0] = cur;
		for (int k = 1; k < crpm_pkg::PAT_MAX; k++) begin
			tail[k] = win[k-1];
		end
	end

	always_comb begin
		logic ok;
		for (int p = 0; p < crpm_pkg::PAT_COUNT; p++) begin
			ok = 1'b1;
			for (int k = 0; k < crpm_pkg::PAT_MAX; k++) begin
				if (4'(k) < crpm_pkg::PAT_LEN[p] &&
				    tail[k] != crpm_pkg::PAT_TEXT[p][8*k +: 8]) begin
					ok = 1'b0;
				end
			end
			hits[p] = ok;
		end
	end

	always_comb begin
		sudo_word = 1'b1;
		for (int k = 0; k < 4; k++) begin
			if (tail[k] != crpm_pkg::SUDO_WORD[8*k +: 8]) begin
				sudo_word = 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/command_risk_pattern_matcher.sv =====
// Top level: byte history chain, sticky substring hits and rule evaluation.
// Result: registered, valid in the cycle after the beat marked last.
// Throughput: one byte per cycle unless a result waits for res_ready; all
// substrings are compared at once with the current byte and the history chain.
// Reset (arst_n low) clears history, hits, length count and result valid.
// State also returns to reset after each last beat; no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module command_risk_pattern_matcher #(
	parameter int WINDOW_DEPTH = 11
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cmd_valid,
	output logic            cmd_ready,
	input  wire logic [7:0] char_code,
	input  wire logic       last_char,
	output logic            res_valid,
	input  wire logic       res_ready,
	output logic [1:0]      risk_level,
	output logic [8:0]      reason_flags
);

	logic                 acc;
	crpm_pkg::char_t      folded;
	crpm_pkg::win_ctl_t   ctl;
	crpm_pkg::char_t      win [WINDOW_DEPTH];
	crpm_pkg::hits_t      hits_now;
	crpm_pkg::hits_t      hits_all;
	crpm_pkg::hits_t      hits_q;
	logic                 sudo_word;
	crpm_pkg::count_t     cnt_q;
	logic                 shell;
	crpm_pkg::rules_t     rules;
	crpm_pkg::risk_t      risk;
	logic                 res_valid_q;
	crpm_pkg::risk_t      risk_q;
	crpm_pkg::rules_t     flags_q;

	assign cmd_ready = !res_valid_q || res_ready;
	assign acc       = cmd_valid && cmd_ready;
	assign folded    = (char_code >= "A" && char_code <= "Z") ? char_code + 8'd32 : char_code;

	assign ctl.shift = acc;
	assign ctl.clear = acc && last_char;

	for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
		crpm_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.d      ((i == 0) ? folded : win[(i == 0) ? 0 : i-1]),
			.q      (win[i])
		);
	end

	crpm_match #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_match (
		.cur       (folded),
		.win       (win),
		.hits      (hits_now),
		.sudo_word (sudo_word)
	);

	assign hits_all = hits_q | hits_now;
	assign shell    = hits_all[crpm_pkg::P_SH] || hits_all[crpm_pkg::P_BASH] ||
	                  hits_all[crpm_pkg::P_ZSH];

	always_comb begin
		rules = '0;
		rules[crpm_pkg::R_SUDO]     = hits_all[crpm_pkg::P_SUDO] ||
		                              (sudo_word && cnt_q == crpm_pkg::SUDO_PRIOR);
		rules[crpm_pkg::R_RMRF]     = hits_all[crpm_pkg::P_RMRF] || hits_all[crpm_pkg::P_RMFR];
		rules[crpm_pkg::R_CURLPIPE] = hits_all[crpm_pkg::P_CURL] &&
		                              hits_all[crpm_pkg::P_PIPE] && shell;
		rules[crpm_pkg::R_WGETPIPE] = hits_all[crpm_pkg::P_WGET] &&
		                              hits_all[crpm_pkg::P_PIPE] && shell;
		rules[crpm_pkg::R_CHMOD]    = hits_all[crpm_pkg::P_CHMOD] || hits_all[crpm_pkg::P_CHOWN];
		rules[crpm_pkg::R_SSH]      = hits_all[crpm_pkg::P_TSSH] || hits_all[crpm_pkg::P_HSSH] ||
		                              hits_all[crpm_pkg::P_DSSH];
		rules[crpm_pkg::R_AWS]      = hits_all[crpm_pkg::P_TAWS] || hits_all[crpm_pkg::P_HAWS] ||
		                              hits_all[crpm_pkg::P_DAWS];
		rules[crpm_pkg::R_REMOTE]   = hits_all[crpm_pkg::P_SSH] || hits_all[crpm_pkg::P_SCP] ||
		                              hits_all[crpm_pkg::P_RSYNC];
		rules[crpm_pkg::R_INSTALL]  = hits_all[crpm_pkg::P_CURL] || hits_all[crpm_pkg::P_WGET] ||
		                              hits_all[crpm_pkg::P_NPM] || hits_all[crpm_pkg::P_PIP] ||
		                              hits_all[crpm_pkg::P_BREW];
	end

	always_comb begin
		if (|rules[crpm_pkg::R_AWS:crpm_pkg::R_SUDO]) begin
			risk = crpm_pkg::RISK_HIGH;
		end else if (|rules[crpm_pkg::R_INSTALL:crpm_pkg::R_REMOTE]) begin
			risk = crpm_pkg::RISK_MEDIUM;
		end else begin
			risk = crpm_pkg::RISK_LOW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q <= '0;
			cnt_q  <= '0;
		end else if (acc) begin
			if (last_char) begin
				hits_q <= '0;
				cnt_q  <= '0;
			end else begin
				hits_q <= hits_all;
				if (cnt_q < crpm_pkg::COUNT_SAT) begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (acc && last_char) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && last_char) begin
			risk_q  <= risk;
			flags_q <= rules;
		end
	end

	assign res_valid    = res_valid_q;
	assign risk_level   = risk_q;
	assign reason_flags = flags_q;

	`CRPM_ASSERT(a_last_gives_result, (acc && last_char) |=> res_valid_q)
	`CRPM_ASSERT(a_last_clears_state, (acc && last_char) |=> (cnt_q == '0 && hits_q == '0))
	`CRPM_ASSERT_MSG(a_risk_matches_flags,
		res_valid_q |-> ((risk_q == crpm_pkg::RISK_HIGH) == (|flags_q[crpm_pkg::R_AWS:0])),
		"risk level disagrees with rule flags")
	`CRPM_ASSERT_MSG(a_count_saturates, cnt_q <= crpm_pkg::COUNT_SAT,
		"length count beyond saturation")

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench for command_risk_pattern_matcher: random and directed commands vs. a predictor.
module tb_top;

	localparam int HIST_DEPTH  = 11;
	localparam int FRAG_COUNT  = 32;
	localparam int BEAT_TARGET = 1400;
	localparam int CALM_TAIL   = 150;
	localparam int DRAIN_WAIT  = 8;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [7:0] code;
		logic       fin;
	} beat_t;

	typedef struct packed {
		crpm_pkg::risk_t  level;
		crpm_pkg::rules_t flags;
	} verdict_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cmd_valid = 1'b0;
	logic       cmd_ready;
	logic [7:0] char_code = 8'h00;
	logic       last_char = 1'b0;
	logic       res_valid;
	logic       res_ready = 1'b0;
	logic [1:0] risk_level;
	logic [8:0] reason_flags;

	beat_t      beat_q [$];
	verdict_t   verdict_q [$];
	logic [7:0] draft [$];
	int         errors = 0;
	int         cycle_count = 0;
	int         send_gap = 0;
	int         sink_stall = 0;

	logic [7:0]        history [HIST_DEPTH];
	crpm_pkg::hits_t   seen_hits;
	crpm_pkg::count_t  byte_count;

	// Same order as the P_* indexes of the package.
	string pat_text [crpm_pkg::PAT_COUNT] = '{
		"sudo ", "rm -rf", "rm -fr", "curl ", "wget ", "|", " sh", " bash", " zsh",
		"chmod -r", "chown -r", " ~/.ssh", "$home/.ssh", "/.ssh/", " ~/.aws",
		"$home/.aws", "/.aws/", "ssh ", "scp ", "rsync ", "npm install",
		"pip install", "brew install"
	};

	string fragments [FRAG_COUNT] = '{
		"sudo", "sudo ", "rm -rf ", "rm -fr", "rm -r", "curl ", "wget ", "|",
		" | ", " sh", " bash", " zsh", "chmod -r ", "chown -r", "chmod 777", " ~/.ssh",
		"$home/.ssh", "/.ssh/", " ~/.aws", "$home/.aws", "/.aws/", "ssh ", "scp ",
		"rsync ", "npm install", "pip install", "brew install", "install", "ls -la",
		"/tmp/x", " ", "git "
	};

	string directed [24] = '{
		"sudo", "SuDo", "sudo ls", "xsudo", "rm -rf /", "RM -FR tmp", "curl x | sh",
		"WGET u|bash", "curl a |zsh", "chmod -R 755 .", "chown -r me f", "cat ~/.ssh/id",
		"ls $HOME/.SSH", "cp /.aws/ x", "vi ~/.aws", "$HOME/.aws", "ssh h", "scp a b",
		"rsync -a", "npm install x", "pip install q", "brew install git", "rm -", "rf x"
	};

	command_risk_pattern_matcher dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.char_code    (char_code),
		.last_char    (last_char),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.risk_level   (risk_level),
		.reason_flags (reason_flags)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic void clear_state();
		foreach (history[i]) history[i] = 8'h00;
		seen_hits = '0;
		byte_count = '0;
	endfunction

	function automatic logic [7:0] lower_byte(input logic [7:0] c);
		if (c >= "A" && c <= "Z") return c + 8'd32;
		return c;
	endfunction

	function automatic logic tail_matches(input logic [7:0] span [HIST_DEPTH + 1],
		input string p);
		int n;
		n = p.len();
		if (n > HIST_DEPTH + 1) return 1'b0;
		for (int k = 0; k < n; k++)
			if (span[HIST_DEPTH + 1 - n + k] != p[k]) return 1'b0;
		return 1'b1;
	endfunction

	// Advance the matcher state by one byte; queue the verdict on the last one.
	function automatic void scan_byte(input logic [7:0] raw, input logic fin);
		logic [7:0]       span [HIST_DEPTH + 1];
		logic [7:0]       c;
		logic             shell;
		crpm_pkg::rules_t flags;
		verdict_t         v;
		c = lower_byte(raw);
		for (int i = 0; i < HIST_DEPTH; i++) span[HIST_DEPTH - 1 - i] = history[i];
		span[HIST_DEPTH] = c;
		for (int i = 0; i < crpm_pkg::PAT_COUNT; i++)
			if (tail_matches(span, pat_text[i])) seen_hits[i] = 1'b1;
		if (byte_count < crpm_pkg::COUNT_SAT) byte_count++;
		for (int i = HIST_DEPTH - 1; i > 0; i--) history[i] = history[i - 1];
		history[0] = c;
		if (!fin) return;

		shell = seen_hits[crpm_pkg::P_SH] | seen_hits[crpm_pkg::P_BASH] |
			seen_hits[crpm_pkg::P_ZSH];
		flags = '0;
		flags[crpm_pkg::R_SUDO] = seen_hits[crpm_pkg::P_SUDO] || (byte_count == 3'd4 &&
			{span[HIST_DEPTH - 3], span[HIST_DEPTH - 2], span[HIST_DEPTH - 1],
			span[HIST_DEPTH]} == "sudo");
		flags[crpm_pkg::R_RMRF] = seen_hits[crpm_pkg::P_RMRF] | seen_hits[crpm_pkg::P_RMFR];
		flags[crpm_pkg::R_CURLPIPE] = seen_hits[crpm_pkg::P_CURL] &
			seen_hits[crpm_pkg::P_PIPE] & shell;
		flags[crpm_pkg::R_WGETPIPE] = seen_hits[crpm_pkg::P_WGET] &
			seen_hits[crpm_pkg::P_PIPE] & shell;
		flags[crpm_pkg::R_CHMOD] = seen_hits[crpm_pkg::P_CHMOD] | seen_hits[crpm_pkg::P_CHOWN];
		flags[crpm_pkg::R_SSH] = seen_hits[crpm_pkg::P_TSSH] | seen_hits[crpm_pkg::P_HSSH] |
			seen_hits[crpm_pkg::P_DSSH];
		flags[crpm_pkg::R_AWS] = seen_hits[crpm_pkg::P_TAWS] | seen_hits[crpm_pkg::P_HAWS] |
			seen_hits[crpm_pkg::P_DAWS];
		flags[crpm_pkg::R_REMOTE] = seen_hits[crpm_pkg::P_SSH] | seen_hits[crpm_pkg::P_SCP] |
			seen_hits[crpm_pkg::P_RSYNC];
		flags[crpm_pkg::R_INSTALL] = seen_hits[crpm_pkg::P_CURL] |
			seen_hits[crpm_pkg::P_WGET] | seen_hits[crpm_pkg::P_NPM] |
			seen_hits[crpm_pkg::P_PIP] | seen_hits[crpm_pkg::P_BREW];

		v.flags = flags;
		if (|flags[crpm_pkg::R_AWS:crpm_pkg::R_SUDO]) v.level = crpm_pkg::RISK_HIGH;
		else if (|flags[crpm_pkg::R_INSTALL:crpm_pkg::R_REMOTE])
			v.level = crpm_pkg::RISK_MEDIUM;
		else v.level = crpm_pkg::RISK_LOW;
		verdict_q = {verdict_q, v};
		clear_state();
	endfunction

	function automatic logic [7:0] vary_case(input logic [7:0] c);
		if (c >= "a" && c <= "z" && $urandom_range(0, 3) == 0) return c - 8'd32;
		return c;
	endfunction

	function automatic void append_text(input string s, input logic mixed);
		logic [7:0] c;
		for (int i = 0; i < s.len(); i++) begin
			c = mixed ? vary_case(s[i]) : s[i];
			draft = {draft, c};
		end
	endfunction

	function automatic void commit();
		beat_t b;
		foreach (draft[i]) begin
			b.code = draft[i];
			b.fin = (i == draft.size() - 1);
			beat_q = {beat_q, b};
		end
		draft.delete();
	endfunction

	task automatic report_mismatch(input string what);
		errors++;
		$display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		beat_t b;
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			char_code <= 8'h00;
			last_char <= 1'b0;
			send_gap = 0;
		end else if (!cmd_valid || cmd_ready) begin
			if (send_gap > 0) begin
				send_gap--;
				cmd_valid <= 1'b0;
			end else if (beat_q.size() > 0) begin
				b = beat_q.pop_front();
				char_code <= b.code;
				last_char <= b.fin;
				cmd_valid <= 1'b1;
				if (beat_q.size() > CALM_TAIL && $urandom_range(0, 9) == 0)
					send_gap = $urandom_range(1, 16);
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			sink_stall = 0;
		end else if (sink_stall > 0) begin
			sink_stall--;
			res_ready <= 1'b0;
		end else if (beat_q.size() > CALM_TAIL && $urandom_range(0, 11) == 0) begin
			sink_stall = $urandom_range(0, 15);
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		verdict_t v;
		if (arst_n) begin
			if (cmd_valid && cmd_ready) scan_byte(char_code, last_char);
			if (res_valid && res_ready) begin
				if (verdict_q.size() == 0) begin
					report_mismatch($sformatf("unexpected beat: risk %0d flags %03h",
						risk_level, reason_flags));
				end else begin
					v = verdict_q.pop_front();
					if (risk_level !== v.level)
						report_mismatch($sformatf("risk_level %0d, predicted %0d",
							risk_level, v.level));
					if (reason_flags !== v.flags)
						report_mismatch($sformatf("reason_flags %03h, predicted %03h",
							reason_flags, v.flags));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int    kind;
		int    n;
		string s;
		clear_state();

		foreach (directed[i]) begin
			append_text(directed[i], 1'b0);
			commit();
		end
		draft = {draft, 8'h00};
		commit();
		draft = {draft, 8'hFF};
		commit();
		append_text("curl", 1'b0);
		draft = {draft, 8'h80};
		append_text(" | sh", 1'b0);
		commit();
		draft = {draft, 8'h00};
		append_text("sudo ", 1'b0);
		draft = {draft, 8'hC1};
		commit();

		while (beat_q.size() < BEAT_TARGET) begin
			kind = $urandom_range(0, 9);
			if (kind < 8) begin
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 11) == 0)
						draft = {draft, 8'($urandom_range(0, 255))};
					else
						append_text(fragments[$urandom_range(0, FRAG_COUNT - 1)], 1'b1);
				end
			end else if (kind == 8) begin
				s = $urandom_range(0, 1) ? "sudo" : fragments[$urandom_range(0, FRAG_COUNT - 1)];
				n = $urandom_range(1, (s.len() < 5) ? s.len() : 5);
				append_text(s.substr(0, n - 1), 1'b1);
			end else begin
				repeat ($urandom_range(1, 14)) draft = {draft, 8'($urandom_range(0, 255))};
			end
			commit();
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		while (beat_q.size() > 0 || cmd_valid || verdict_q.size() > 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

endmodule
